// ===== hw/rtl/rcrgq_pkg.sv =====
// Shared types and constants for the ROI crop, resize and gray quantizer.
package rcrgq_pkg;

    localparam int OUT_WIDTH  = 48;
    localparam int OUT_HEIGHT = 48;
    localparam int MIN_CROP   = 4;

    localparam int OUT_TOTAL = OUT_WIDTH * OUT_HEIGHT;
    localparam int POS_W     = $clog2(OUT_TOTAL);
    localparam int OX_W      = $clog2(OUT_WIDTH);
    localparam int OY_W      = $clog2(OUT_HEIGHT);

    localparam int COORD_W     = 11;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 3;
    localparam int ADDR_W      = 24;
    localparam int INDEX_W     = 12;

    // Exact division by the output size: floor(n * RECIP / 2^SHIFT) equals
    // floor(n / size) for every product n that the scaler can form.
    localparam int X_PROD_W  = OX_W + COORD_W;
    localparam int X_SHIFT   = X_PROD_W + $clog2(OUT_WIDTH);
    localparam int X_RECIP_W = X_PROD_W + 1;
    localparam logic [X_RECIP_W-1:0] X_RECIP =
        X_RECIP_W'((2**X_SHIFT + OUT_WIDTH - 1) / OUT_WIDTH);

    localparam int Y_PROD_W  = OY_W + COORD_W;
    localparam int Y_SHIFT   = Y_PROD_W + $clog2(OUT_HEIGHT);
    localparam int Y_RECIP_W = Y_PROD_W + 1;
    localparam logic [Y_RECIP_W-1:0] Y_RECIP =
        Y_RECIP_W'((2**Y_SHIFT + OUT_HEIGHT - 1) / OUT_HEIGHT);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH    = 3'd0,
        REG_FRAME_HEIGHT   = 3'd1,
        REG_LINE_STRIDE    = 3'd2,
        REG_ROI_LEFT       = 3'd3,
        REG_ROI_TOP        = 3'd4,
        REG_ROI_WIDTH      = 3'd5,
        REG_ROI_HEIGHT     = 3'd6,
        REG_QUANT_EXPONENT = 3'd7
    } reg_index_t;

    localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd320;
    localparam logic [10:0] FRAME_HEIGHT_RESET = 11'd240;
    localparam logic [12:0] LINE_STRIDE_RESET  = 13'd640;
    localparam logic [11:0] ROI_SIZE_RESET     = 12'd48;

    localparam logic OP_START    = 1'b0;
    localparam logic OP_CONTINUE = 1'b1;

    typedef struct packed {
        logic [10:0]        frame_width;
        logic [10:0]        frame_height;
        logic [12:0]        line_stride;
        logic signed [11:0] roi_left;
        logic signed [11:0] roi_top;
        logic [11:0]        roi_width;
        logic [11:0]        roi_height;
        logic signed [4:0]  quant_exponent;
    } cfg_t;

    typedef struct packed {
        logic        operation;
        logic [15:0] pixel_word;
    } item_t;

    typedef struct packed {
        logic               read_request;
        logic [23:0]        read_address;
        logic               value_valid;
        logic signed [7:0]  out_value;
        logic [11:0]        out_index;
        logic               last_sample;
        logic               gray_fill;
    } result_t;

    typedef struct packed {
        logic load_item;
        logic start_crop;
        logic clear_result;
        logic gray;
        logic sample;
        logic mul;
        logic div;
        logic src;
        logic addr;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic op;
        logic active;
        logic small_crop;
        logic last;
    } dp_status_t;

endpackage

// ===== hw/rtl/rcrgq_dp.sv =====
// Datapath: crop clamp, raster counters, source address scaler and gray quantizer.
module rcrgq_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rcrgq_pkg::item_t       item,
    input  rcrgq_pkg::cfg_t        cfg,
    input  rcrgq_pkg::dp_cmd_t     cmd,
    output rcrgq_pkg::dp_status_t  status,
    output rcrgq_pkg::result_t     result
);

    localparam int CW = rcrgq_pkg::COORD_W;
    localparam int XW = rcrgq_pkg::X_PROD_W;
    localparam int YW = rcrgq_pkg::Y_PROD_W;
    localparam int XQW = rcrgq_pkg::X_PROD_W + rcrgq_pkg::X_RECIP_W;
    localparam int YQW = rcrgq_pkg::Y_PROD_W + rcrgq_pkg::Y_RECIP_W;
    localparam logic [15:0] WEIGHT_R = 16'd77;
    localparam logic [15:0] WEIGHT_G = 16'd150;
    localparam logic [15:0] WEIGHT_B = 16'd29;
    localparam logic signed [13:0] MIN_CROP_S = 14'(rcrgq_pkg::MIN_CROP);

    logic                            op_reg, op_next;
    logic [15:0]                     pixel_reg, pixel_next;
    logic                            active_reg, active_next;
    logic                            small_reg, small_next;
    logic [CW-1:0]                   crop_left_reg, crop_left_next;
    logic [CW-1:0]                   crop_top_reg, crop_top_next;
    logic [CW-1:0]                   crop_cols_reg, crop_cols_next;
    logic [CW-1:0]                   crop_rows_reg, crop_rows_next;
    logic [rcrgq_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [rcrgq_pkg::OX_W-1:0]      ox_reg, ox_next;
    logic [rcrgq_pkg::OY_W-1:0]      oy_reg, oy_next;
    logic [7:0]                      gray_reg, gray_next;
    logic [XW-1:0]                   prod_x_reg, prod_x_next;
    logic [YW-1:0]                   prod_y_reg, prod_y_next;
    logic [CW-1:0]                   qx_reg, qx_next;
    logic [CW-1:0]                   qy_reg, qy_next;
    logic [CW-1:0]                   sx_reg, sx_next;
    logic [CW-1:0]                   sy_reg, sy_next;
    rcrgq_pkg::result_t              result_reg, result_next;

    logic [CW-1:0]      x0, y0;
    logic signed [13:0] x_end, y_end, x1, y1, cw, ch, fw_s, fh_s;
    logic               small_start;
    logic [7:0]         r8, g8, b8;
    logic [15:0]        gray_sum;
    logic               e_pos;
    logic [3:0]         sh;
    logic [15:0]        rounded;
    logic [7:0]         quant_value, fill_value, sample_value;
    logic               last;
    logic [XQW-1:0]     qx_full;
    logic [YQW-1:0]     qy_full;
    logic [CW:0]        sum_x, sum_y;
    logic [CW-1:0]      sx_lim, sy_lim;
    logic [23:0]        address;

    always_comb
    begin
        x0 = cfg.roi_left[11] ? '0 : cfg.roi_left[CW-1:0];
        y0 = cfg.roi_top[11] ? '0 : cfg.roi_top[CW-1:0];
        fw_s = $signed({3'b000, cfg.frame_width});
        fh_s = $signed({3'b000, cfg.frame_height});
        x_end = $signed({{2{cfg.roi_left[11]}}, cfg.roi_left}) + $signed({2'b00, cfg.roi_width});
        y_end = $signed({{2{cfg.roi_top[11]}}, cfg.roi_top}) + $signed({2'b00, cfg.roi_height});
        x1 = (x_end > fw_s) ? fw_s : x_end;
        y1 = (y_end > fh_s) ? fh_s : y_end;
        cw = x1 - $signed({3'b000, x0});
        ch = y1 - $signed({3'b000, y0});
        small_start = (cw < MIN_CROP_S) || (ch < MIN_CROP_S);
    end

    always_comb
    begin
        r8 = {pixel_reg[15:11], pixel_reg[15:13]};
        g8 = {pixel_reg[10:5], pixel_reg[10:9]};
        b8 = {pixel_reg[4:0], pixel_reg[4:2]};
        gray_sum = 16'(r8) * WEIGHT_R + 16'(g8) * WEIGHT_G + 16'(b8) * WEIGHT_B;
    end

    always_comb
    begin
        e_pos = !cfg.quant_exponent[4] && (cfg.quant_exponent != 5'sd0);
        sh = cfg.quant_exponent[3:0];
        rounded = (16'(gray_reg) + (16'd1 << (sh - 4'd1))) >> sh;
        if (!e_pos)
        begin
            rounded = 16'(gray_reg);
        end
        quant_value = (rounded > 16'd127) ? 8'd127 : rounded[7:0];
        fill_value = e_pos ? (8'd128 >> sh) : 8'd127;
        sample_value = small_reg ? fill_value : quant_value;
        last = (ox_reg == rcrgq_pkg::OX_W'(rcrgq_pkg::OUT_WIDTH - 1))
            && (oy_reg == rcrgq_pkg::OY_W'(rcrgq_pkg::OUT_HEIGHT - 1));
    end

    always_comb
    begin
        qx_full = XQW'(prod_x_reg) * XQW'(rcrgq_pkg::X_RECIP);
        qy_full = YQW'(prod_y_reg) * YQW'(rcrgq_pkg::Y_RECIP);
        sum_x = (CW + 1)'(crop_left_reg) + (CW + 1)'(qx_reg);
        sum_y = (CW + 1)'(crop_top_reg) + (CW + 1)'(qy_reg);
        sx_lim = (cfg.frame_width == '0) ? '0 : cfg.frame_width - 11'd1;
        sy_lim = (cfg.frame_height == '0) ? '0 : cfg.frame_height - 11'd1;
        address = 24'(sy_reg) * 24'(cfg.line_stride) + 24'({sx_reg, 1'b0});
    end

    always_comb
    begin
        op_next = op_reg;
        pixel_next = pixel_reg;
        active_next = active_reg;
        small_next = small_reg;
        crop_left_next = crop_left_reg;
        crop_top_next = crop_top_reg;
        crop_cols_next = crop_cols_reg;
        crop_rows_next = crop_rows_reg;
        pos_next = pos_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        gray_next = gray_reg;
        prod_x_next = prod_x_reg;
        prod_y_next = prod_y_reg;
        qx_next = qx_reg;
        qy_next = qy_reg;
        sx_next = sx_reg;
        sy_next = sy_reg;
        result_next = result_reg;

        if (cmd.load_item)
        begin
            op_next = item.operation;
            pixel_next = item.pixel_word;
        end

        if (cmd.start_crop)
        begin
            active_next = 1'b1;
            small_next = small_start;
            pos_next = '0;
            ox_next = '0;
            oy_next = '0;
            crop_left_next = small_start ? '0 : x0;
            crop_top_next = small_start ? '0 : y0;
            crop_cols_next = small_start ? '0 : cw[CW-1:0];
            crop_rows_next = small_start ? '0 : ch[CW-1:0];
            result_next = '0;
            result_next.gray_fill = small_start;
        end

        if (cmd.clear_result)
        begin
            result_next = '0;
        end

        if (cmd.gray)
        begin
            gray_next = gray_sum[15:8];
        end

        if (cmd.sample)
        begin
            result_next = '0;
            result_next.value_valid = 1'b1;
            result_next.out_value = sample_value;
            result_next.out_index = rcrgq_pkg::INDEX_W'(pos_reg);
            result_next.last_sample = last;
            result_next.gray_fill = small_reg;
            if (last)
            begin
                active_next = 1'b0;
                pos_next = '0;
                ox_next = '0;
                oy_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (ox_reg == rcrgq_pkg::OX_W'(rcrgq_pkg::OUT_WIDTH - 1))
                begin
                    ox_next = '0;
                    oy_next = oy_reg + 1'b1;
                end
                else
                begin
                    ox_next = ox_reg + 1'b1;
                end
            end
        end

        if (cmd.mul)
        begin
            prod_x_next = XW'(ox_reg) * XW'(crop_cols_reg);
            prod_y_next = YW'(oy_reg) * YW'(crop_rows_reg);
        end

        if (cmd.div)
        begin
            qx_next = CW'(qx_full >> rcrgq_pkg::X_SHIFT);
            qy_next = CW'(qy_full >> rcrgq_pkg::Y_SHIFT);
        end

        if (cmd.src)
        begin
            sx_next = (sum_x >= (CW + 1)'(cfg.frame_width)) ? sx_lim : sum_x[CW-1:0];
            sy_next = (sum_y >= (CW + 1)'(cfg.frame_height)) ? sy_lim : sum_y[CW-1:0];
        end

        if (cmd.addr)
        begin
            result_next.read_request = 1'b1;
            result_next.read_address = address;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            small_reg <= 1'b0;
            pos_reg <= '0;
            ox_reg <= '0;
            oy_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
            small_reg <= small_next;
            pos_reg <= pos_next;
            ox_reg <= ox_next;
            oy_reg <= oy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        pixel_reg <= pixel_next;
        crop_left_reg <= crop_left_next;
        crop_top_reg <= crop_top_next;
        crop_cols_reg <= crop_cols_next;
        crop_rows_reg <= crop_rows_next;
        gray_reg <= gray_next;
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        qx_reg <= qx_next;
        qy_reg <= qy_next;
        sx_reg <= sx_next;
        sy_reg <= sy_next;
        result_reg <= result_next;
    end

    assign status.op = op_reg;
    assign status.active = active_reg;
    assign status.small_crop = small_reg;
    assign status.last = last;
    assign result = result_reg;

endmodule

// ===== hw/rtl/rcrgq_ctrl.sv =====
// Controller state machine that sequences the datapath for each input beat.
module rcrgq_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   out_free,
    input  rcrgq_pkg::dp_status_t  status,
    output logic                   item_stall,
    output rcrgq_pkg::dp_cmd_t     cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DECODE = 9'b000000010,
        ST_CHECK  = 9'b000000100,
        ST_QUANT  = 9'b000001000,
        ST_MUL    = 9'b000010000,
        ST_DIV    = 9'b000100000,
        ST_SRC    = 9'b001000000,
        ST_ADDR   = 9'b010000000,
        ST_EMIT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        item_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.op == rcrgq_pkg::OP_START)
                begin
                    cmd.start_crop = 1'b1;
                    state_next = ST_CHECK;
                end
                else if (!status.active)
                begin
                    cmd.clear_result = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.gray = 1'b1;
                    state_next = ST_QUANT;
                end
            end
            ST_CHECK:
            begin
                state_next = status.small_crop ? ST_EMIT : ST_MUL;
            end
            ST_QUANT:
            begin
                cmd.sample = 1'b1;
                state_next = (status.last || status.small_crop) ? ST_EMIT : ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div = 1'b1;
                state_next = ST_SRC;
            end
            ST_SRC:
            begin
                cmd.src = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                cmd.addr = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/roi_crop_resize_gray_quantize.sv =====
// Top level of the ROI crop, resize and gray quantizer with its register file.
//
//   channel   direction  handshake                  payload
//   item      in         item_valid / item_stall    rcrgq_pkg::item_t
//   result    out        result_valid / result_stall rcrgq_pkg::result_t
//   cfg       in         cfg_write_en               cfg_index, cfg_data
//
// Every beat in gives exactly one beat out. A pixel beat that leads to a further
// fetch passes from acceptance to the output register through gray, quantize,
// then the scaler's two multiplies and clamp ahead of the stride multiply.
// Start beats run the scaler unless in fill mode; fill and idle beats skip it.
// Reset restores the register defaults and leaves no image active.
// A new beat is taken while the previous result is still stalled in the output
// register; the next result then waits for that register to empty.
module roi_crop_resize_gray_quantize (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [rcrgq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rcrgq_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  rcrgq_pkg::item_t                    item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output rcrgq_pkg::result_t                  result
);

    rcrgq_pkg::cfg_t        cfg_reg, cfg_next;
    logic                   result_valid_reg, result_valid_next;
    rcrgq_pkg::result_t     result_reg, result_next;
    rcrgq_pkg::dp_cmd_t     cmd;
    rcrgq_pkg::dp_status_t  status;
    rcrgq_pkg::result_t     dp_result;
    logic                   out_free;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (rcrgq_pkg::reg_index_t'(cfg_index))
                rcrgq_pkg::REG_FRAME_WIDTH:    cfg_next.frame_width = cfg_data[10:0];
                rcrgq_pkg::REG_FRAME_HEIGHT:   cfg_next.frame_height = cfg_data[10:0];
                rcrgq_pkg::REG_LINE_STRIDE:    cfg_next.line_stride = cfg_data[12:0];
                rcrgq_pkg::REG_ROI_LEFT:       cfg_next.roi_left = cfg_data[11:0];
                rcrgq_pkg::REG_ROI_TOP:        cfg_next.roi_top = cfg_data[11:0];
                rcrgq_pkg::REG_ROI_WIDTH:      cfg_next.roi_width = cfg_data[11:0];
                rcrgq_pkg::REG_ROI_HEIGHT:     cfg_next.roi_height = cfg_data[11:0];
                rcrgq_pkg::REG_QUANT_EXPONENT: cfg_next.quant_exponent = cfg_data[4:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width <= rcrgq_pkg::FRAME_WIDTH_RESET;
            cfg_reg.frame_height <= rcrgq_pkg::FRAME_HEIGHT_RESET;
            cfg_reg.line_stride <= rcrgq_pkg::LINE_STRIDE_RESET;
            cfg_reg.roi_left <= '0;
            cfg_reg.roi_top <= '0;
            cfg_reg.roi_width <= rcrgq_pkg::ROI_SIZE_RESET;
            cfg_reg.roi_height <= rcrgq_pkg::ROI_SIZE_RESET;
            cfg_reg.quant_exponent <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rcrgq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .out_free   (out_free),
        .status     (status),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    rcrgq_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cfg    (cfg_reg),
        .cmd    (cmd),
        .status (status),
        .result (dp_result)
    );

    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next = result_reg;
        if (cmd.emit)
        begin
            result_valid_next = 1'b1;
            result_next = dp_result;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result = result_reg;

    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("input taken again right after a beat was accepted");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_sample)
            |-> (result.out_index == rcrgq_pkg::INDEX_W'(rcrgq_pkg::OUT_TOTAL - 1)))
        else $error("final sample flagged at the wrong raster index");

    a_fill_no_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.gray_fill) |-> !result.read_request)
        else $error("fetch requested while in gray fill mode");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the ROI crop, resize and gray quantizer top level.
module tb;

    import rcrgq_pkg::*;

    localparam int LONG_HOLD = 400;

    class gray_crop_tracker;
        cfg_t    cfg;
        int      position;
        bit      active;
        bit      small_crop;
        int      crop_left;
        int      crop_top;
        int      crop_cols;
        int      crop_rows;
        result_t awaited_samples [$];
        int      errors;

        function new();
            cfg = '0;
            cfg.frame_width = FRAME_WIDTH_RESET;
            cfg.frame_height = FRAME_HEIGHT_RESET;
            cfg.line_stride = LINE_STRIDE_RESET;
            cfg.roi_width = ROI_SIZE_RESET;
            cfg.roi_height = ROI_SIZE_RESET;
            position = 0;
            active = 0;
            small_crop = 0;
            crop_left = 0;
            crop_top = 0;
            crop_cols = 0;
            crop_rows = 0;
            errors = 0;
        endfunction

        function void set_reg(reg_index_t idx, logic [12:0] d);
            case (idx)
                REG_FRAME_WIDTH:    cfg.frame_width = d[10:0];
                REG_FRAME_HEIGHT:   cfg.frame_height = d[10:0];
                REG_LINE_STRIDE:    cfg.line_stride = d;
                REG_ROI_LEFT:       cfg.roi_left = d[11:0];
                REG_ROI_TOP:        cfg.roi_top = d[11:0];
                REG_ROI_WIDTH:      cfg.roi_width = d[11:0];
                REG_ROI_HEIGHT:     cfg.roi_height = d[11:0];
                REG_QUANT_EXPONENT: cfg.quant_exponent = d[4:0];
                default:            ;
            endcase
        endfunction

        function int pending();
            return awaited_samples.size();
        endfunction

        function logic [23:0] source_address(int pos);
            int sx;
            int sy;
            int fw;
            int fh;
            sx = crop_left + (pos % OUT_WIDTH) * crop_cols / OUT_WIDTH;
            sy = crop_top + (pos / OUT_WIDTH) * crop_rows / OUT_HEIGHT;
            fw = int'(cfg.frame_width);
            fh = int'(cfg.frame_height);
            if (sx >= fw) sx = (fw != 0) ? fw - 1 : 0;
            if (sy >= fh) sy = (fh != 0) ? fh - 1 : 0;
            return 24'(sy * int'(cfg.line_stride) + sx * 2);
        endfunction

        function int quantized_gray(logic [15:0] px);
            logic [7:0] r8;
            logic [7:0] g8;
            logic [7:0] b8;
            int gray;
            int e;
            r8 = {px[15:11], px[15:13]};
            g8 = {px[10:5], px[10:9]};
            b8 = {px[4:0], px[4:2]};
            gray = (77 * int'(r8) + 150 * int'(g8) + 29 * int'(b8)) >> 8;
            e = $signed(cfg.quant_exponent);
            if (e > 0) gray = (gray + (1 << (e - 1))) >> e;
            return (gray > 127) ? 127 : gray;
        endfunction

        function int fill_level();
            int e;
            int v;
            e = $signed(cfg.quant_exponent);
            v = (e > 0) ? (128 >> e) : 128;
            return (v > 127) ? 127 : v;
        endfunction

        function void accept_beat(item_t beat);
            result_t r;
            int fx;
            int fy;
            int x0;
            int y0;
            int x1;
            int y1;
            int val;
            bit last;
            r = '0;
            if (beat.operation == OP_START) begin
                fx = $signed(cfg.roi_left);
                fy = $signed(cfg.roi_top);
                x0 = (fx < 0) ? 0 : fx;
                y0 = (fy < 0) ? 0 : fy;
                x1 = fx + int'(cfg.roi_width);
                y1 = fy + int'(cfg.roi_height);
                if (x1 > int'(cfg.frame_width)) x1 = int'(cfg.frame_width);
                if (y1 > int'(cfg.frame_height)) y1 = int'(cfg.frame_height);
                active = 1;
                position = 0;
                if (x1 - x0 < MIN_CROP || y1 - y0 < MIN_CROP) begin
                    small_crop = 1;
                    crop_left = 0;
                    crop_top = 0;
                    crop_cols = 0;
                    crop_rows = 0;
                    r.gray_fill = 1'b1;
                end else begin
                    small_crop = 0;
                    crop_left = x0 & 32'h7FF;
                    crop_top = y0 & 32'h7FF;
                    crop_cols = (x1 - x0) & 32'h1FFF;
                    crop_rows = (y1 - y0) & 32'h1FFF;
                    r.read_request = 1'b1;
                    r.read_address = source_address(0);
                end
            end else if (active) begin
                last = (position + 1 >= OUT_TOTAL);
                val = small_crop ? fill_level() : quantized_gray(beat.pixel_word);
                r.value_valid = 1'b1;
                r.out_value = val[7:0];
                r.out_index = position[11:0];
                r.last_sample = last;
                r.gray_fill = small_crop;
                if (last) begin
                    active = 0;
                    position = 0;
                end else begin
                    position++;
                    if (!small_crop) begin
                        r.read_request = 1'b1;
                        r.read_address = source_address(position);
                    end
                end
            end
            awaited_samples.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR at %0t: %s", $time, msg);
        endtask

        task compare(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %0h, expected %0h", name, got, want));
        endtask

        task check_beat(result_t got);
            result_t want;
            if (awaited_samples.size() == 0) begin
                report("result beat with no item outstanding");
                return;
            end
            want = awaited_samples.pop_front();
            compare("read_request", got.read_request, want.read_request);
            compare("read_address", got.read_address, want.read_address);
            compare("value_valid", got.value_valid, want.value_valid);
            compare("out_value", 32'(got.out_value[7:0]), 32'(want.out_value[7:0]));
            compare("out_index", got.out_index, want.out_index);
            compare("last_sample", got.last_sample, want.last_sample);
            compare("gray_fill", got.gray_fill, want.gray_fill);
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   item_valid;
    logic                   item_stall;
    item_t                  item;
    logic                   result_valid;
    logic                   result_stall;
    result_t                result;

    gray_crop_tracker tracker = new();
    int gap_odds = 2;
    int holds_asked = 0;
    int holds_served = 0;

    roi_crop_resize_gray_quantize uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #(8 * 600000);
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk) begin
        if (result_valid === 1'b1 && result_stall === 1'b0)
            tracker.check_beat(result);
    end

    initial begin
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (holds_served != holds_asked) begin
                holds_served++;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (gap_odds > 0 && $urandom_range(1, 8) <= gap_odds) begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end else begin
                result_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    task automatic send_item(input logic op, input logic [15:0] px);
        item_t beat;
        beat.operation = op;
        beat.pixel_word = px;
        if (gap_odds > 0 && $urandom_range(1, 8) <= gap_odds) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= beat;
        @(posedge clk);
        while (item_stall !== 1'b0) @(posedge clk);
        tracker.accept_beat(beat);
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    task automatic configure(input logic [12:0] fw, input logic [12:0] fh,
                             input logic [12:0] stride, input logic [12:0] left,
                             input logic [12:0] top, input logic [12:0] rw,
                             input logic [12:0] rh, input logic [12:0] qexp);
        logic [12:0] vals [8];
        logic [12:0] keep;
        logic [12:0] word;
        int i;
        vals[0] = fw;
        vals[1] = fh;
        vals[2] = stride;
        vals[3] = left;
        vals[4] = top;
        vals[5] = rw;
        vals[6] = rh;
        vals[7] = qexp;
        for (i = 0; i < 8; i++) begin
            case (reg_index_t'(i))
                REG_FRAME_WIDTH, REG_FRAME_HEIGHT: keep = 13'h07FF;
                REG_LINE_STRIDE:                   keep = 13'h1FFF;
                REG_QUANT_EXPONENT:                keep = 13'h001F;
                default:                           keep = 13'h0FFF;
            endcase
            word = (vals[i] & keep) | (13'($urandom) & ~keep);
            cfg_write_en <= 1'b1;
            cfg_index <= reg_index_t'(i);
            cfg_data <= word;
            @(posedge clk);
            tracker.set_reg(reg_index_t'(i), word);
        end
        cfg_write_en <= 1'b0;
    endtask

    function automatic int pick_size();
        case ($urandom_range(0, 5))
            0:       return 1;
            1:       return 2047;
            2:       return $urandom_range(1, 2047);
            default: return $urandom_range(40, 400);
        endcase
    endfunction

    initial begin
        int k;
        int n;
        int random_beats;
        int fw;
        int fh;
        int stride;
        int left;
        int top;
        int rw;
        int rh;
        int qexp;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        cfg_write_en <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a continue while idle, then a start and extreme pixel words.
        send_item(OP_CONTINUE, 16'hFFFF);
        send_item(OP_START, 16'hFFFF);
        send_item(OP_CONTINUE, 16'h0000);
        send_item(OP_CONTINUE, 16'hFFFF);
        send_item(OP_CONTINUE, 16'hF800);
        send_item(OP_CONTINUE, 16'h07E0);
        send_item(OP_CONTINUE, 16'h001F);
        send_item(OP_START, 16'h5555);
        send_item(OP_CONTINUE, 16'hAAAA);
        settle();

        // Widest frame, ROI hanging off the far corner, shift of eight.
        configure(13'd2047, 13'd2047, 13'd8190, 13'(2000), 13'(2040),
                  13'd4095, 13'd4095, 13'(8));
        send_item(OP_START, 16'h0000);
        send_item(OP_CONTINUE, 16'hFFFF);
        send_item(OP_CONTINUE, 16'h0000);
        settle();

        // Most negative origin with no shift.
        configure(13'd2047, 13'd2047, 13'd8190, 13'(-2048), 13'(-2048),
                  13'd4095, 13'd4095, 13'(-8));
        send_item(OP_START, 16'h0000);
        send_item(OP_CONTINUE, 16'hFFFF);
        settle();

        // Crop too narrow: fill, then the exponent changes under the running image.
        configure(13'd320, 13'd240, 13'd640, 13'(0), 13'(0), 13'd3, 13'd48, 13'(-8));
        send_item(OP_START, 16'h1234);
        send_item(OP_CONTINUE, 16'hFFFF);
        settle();
        configure(13'd320, 13'd240, 13'd640, 13'(2047), 13'(0), 13'd0, 13'd0, 13'(1));
        send_item(OP_CONTINUE, 16'h0000);
        send_item(OP_START, 16'h0000);
        send_item(OP_CONTINUE, 16'h0000);
        settle();
        configure(13'd320, 13'd240, 13'd640, 13'(300), 13'(230), 13'd100, 13'd100, 13'(15));
        send_item(OP_CONTINUE, 16'h0000);
        send_item(OP_START, 16'h0000);
        send_item(OP_CONTINUE, 16'h4321);
        settle();

        // Frame shrinks to nothing, then to five pixels, while the crop stays latched.
        configure(13'd0, 13'd0, 13'd2, 13'(0), 13'(0), 13'd48, 13'd48, 13'(3));
        send_item(OP_CONTINUE, 16'h8421);
        settle();
        configure(13'd5, 13'd5, 13'd8191, 13'(0), 13'(0), 13'd48, 13'd48, 13'(0));
        send_item(OP_CONTINUE, 16'h7BEF);
        send_item(OP_CONTINUE, 16'hFFFF);
        settle();

        // One whole image through to its last sample, with the long output hold-off.
        configure(13'd320, 13'd240, 13'd640, 13'(7), 13'(3), 13'd301, 13'd211, 13'(2));
        send_item(OP_START, 16'h0000);
        for (k = 0; k < OUT_TOTAL; k++) begin
            if (k % 500 == 0) gap_odds = $urandom_range(0, 3);
            if (k == 400) holds_asked++;
            send_item(OP_CONTINUE, 16'($urandom));
        end
        send_item(OP_CONTINUE, 16'($urandom));
        send_item(OP_CONTINUE, 16'($urandom));
        settle();

        random_beats = 0;
        while (random_beats < 1450) begin
            settle();
            gap_odds = (random_beats > 1300) ? 0 : $urandom_range(0, 3);
            fw = pick_size();
            fh = pick_size();
            case ($urandom_range(0, 3))
                0:       stride = 2;
                1:       stride = 8190;
                2:       stride = $urandom_range(2, 8190);
                default: stride = 2 * fw + $urandom_range(0, 64);
            endcase
            case ($urandom_range(0, 9))
                0: begin
                    left = $urandom_range(0, 4095);
                    top = $urandom_range(0, 4095);
                    rw = $urandom_range(0, 6);
                    rh = $urandom_range(0, 4095);
                end
                1: begin
                    left = $urandom_range(0, 1) ? -2048 : 2047;
                    top = $urandom_range(0, 1) ? -2048 : 2047;
                    rw = $urandom_range(0, 1) ? 0 : 4095;
                    rh = $urandom_range(0, 1) ? 0 : 4095;
                end
                default: begin
                    left = $urandom_range(0, fw - 1) - $urandom_range(0, 10);
                    top = $urandom_range(0, fh - 1) - $urandom_range(0, 10);
                    rw = $urandom_range(4, fw + 20);
                    rh = $urandom_range(4, fh + 20);
                end
            endcase
            qexp = $urandom_range(0, 4) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 16) - 8;
            configure(13'(fw), 13'(fh), 13'(stride), 13'(left), 13'(top),
                      13'(rw), 13'(rh), 13'(qexp));
            n = $urandom_range(20, 160);
            if ($urandom_range(0, 4) != 0) send_item(OP_START, 16'($urandom));
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 29) == 0)
                    send_item(OP_START, 16'($urandom));
                else
                    send_item(OP_CONTINUE, 16'($urandom));
            end
            random_beats += n + 1;
        end

        gap_odds = 0;
        settle();
        repeat (20) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
